/* src/pn3_pkg.sv */
// shared types, constants and arithmetic helpers for the 3-d gradient noise unit
// no dependencies
package pn3_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int IDX_BITS   = $clog2(TABLE_SIZE);
  localparam int ENTRY_BITS = 8;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_BITS   = 16;
  localparam int COORD_BITS = 24;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  // coordinate fraction with sign room for the far corner
  typedef logic signed [FRAC_BITS+1:0] pos_t;
  // gradient dot products and interpolated values
  typedef logic signed [FRAC_BITS+2:0] nval_t;
  // fade weight, 0..one
  typedef logic [FRAC_BITS:0] fade_t;
  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic [IDX_BITS-1:0] idx_t;

  typedef struct packed {
    logic                  is_eval;
    idx_t                  idx;
    logic [ENTRY_BITS-1:0] value;
    idx_t                  xi;
    idx_t                  yi;
    idx_t                  zi;
    frac_t                 fx;
    frac_t                 fy;
    frac_t                 fz;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic frac_t fx_mul(input frac_t a, input frac_t b);
    logic [2*FRAC_BITS-1:0] p;
    p = a * b;
    return p[2*FRAC_BITS-1:FRAC_BITS];
  endfunction

  function automatic fade_t fade_mix(input frac_t t3, input frac_t t4, input frac_t t5);
    logic signed [FRAC_BITS+7:0] r;
    r = $signed({8'd0, t5}) * (FRAC_BITS+8)'(6) - $signed({8'd0, t4}) * (FRAC_BITS+8)'(15)
        + $signed({8'd0, t3}) * (FRAC_BITS+8)'(10);
    if (r < 0) begin
      return '0;
    end else if (r > (FRAC_BITS+8)'(1 << FRAC_BITS)) begin
      return fade_t'(1 << FRAC_BITS);
    end
    return r[FRAC_BITS:0];
  endfunction

  function automatic nval_t grad(input logic [3:0] h, input pos_t x, input pos_t y,
                                 input pos_t z);
    pos_t  u;
    pos_t  v;
    nval_t su;
    nval_t sv;
    u = h[3] ? y : x;
    if (h[3:2] == 2'b00) begin
      v = y;
    end else if (h == 4'd12 || h == 4'd14) begin
      v = x;
    end else begin
      v = z;
    end
    su = h[0] ? -nval_t'(u) : nval_t'(u);
    sv = h[1] ? -nval_t'(v) : nval_t'(v);
    return su + sv;
  endfunction

  function automatic nval_t lerp(input fade_t t, input nval_t a, input nval_t b);
    logic signed [FRAC_BITS+3:0]  d;
    logic signed [2*FRAC_BITS+5:0] p;
    logic signed [2*FRAC_BITS+5:0] s;
    logic signed [FRAC_BITS+3:0]  sum;
    d   = (FRAC_BITS+4)'(b) - (FRAC_BITS+4)'(a);
    p   = $signed({1'b0, t}) * d;
    s   = p >>> FRAC_BITS;
    sum = (FRAC_BITS+4)'(a) + s[FRAC_BITS+3:0];
    return sum[FRAC_BITS+2:0];
  endfunction

endpackage

/* src/pn3_ram.sv */
// permutation table copy: one write port, two registered read ports
// depends on pn3_pkg
module pn3_ram import pn3_pkg::*; (
  input  logic                  clk,
  input  logic                  we,
  input  idx_t                  waddr,
  input  logic [ENTRY_BITS-1:0] wdata,
  input  idx_t                  raddr0,
  input  idx_t                  raddr1,
  output logic [ENTRY_BITS-1:0] rdata0,
  output logic [ENTRY_BITS-1:0] rdata1
);

  logic [ENTRY_BITS-1:0] mem [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

/* src/pn3_front.sv */
// front end: accepts a beat and splits it into a queue item
// depends on pn3_pkg
module pn3_front import pn3_pkg::*; (
  input  logic                  rst,
  input  logic                  start,
  input  logic                  action,
  input  logic [IDX_BITS-1:0]   entry_index,
  input  logic [ENTRY_BITS-1:0] entry_value,
  input  logic [COORD_BITS-1:0] coord_x,
  input  logic [COORD_BITS-1:0] coord_y,
  input  logic [COORD_BITS-1:0] coord_z,
  input  queue_stat_t           qstat,
  output logic                  busy,
  output logic                  push,
  output item_t                 item
);

  assign busy = rst || qstat.full;
  assign push = start && !busy;

  always_comb begin
    item.is_eval = (action == ACT_EVAL);
    item.idx     = entry_index;
    item.value   = entry_value;
    item.xi      = coord_x[FRAC_BITS +: IDX_BITS];
    item.yi      = coord_y[FRAC_BITS +: IDX_BITS];
    item.zi      = coord_z[FRAC_BITS +: IDX_BITS];
    item.fx      = coord_x[FRAC_BITS-1:0];
    item.fy      = coord_y[FRAC_BITS-1:0];
    item.fz      = coord_z[FRAC_BITS-1:0];
  end

endmodule

/* src/pn3_queue.sv */
// two-entry queue between front and back
// depends on pn3_pkg
module pn3_queue import pn3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  item_t       push_item,
  input  logic        pop,
  output item_t       head,
  output queue_stat_t stat
);

  item_t      mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign head       = mem[rp];
  assign stat.full  = (cnt == 2'd2);
  assign stat.empty = (cnt == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

/* src/pn3_back.sv */
// back end: hash pipeline over replicated tables, fade, gradients, trilinear blend
// depends on pn3_pkg and pn3_ram
module pn3_back import pn3_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  item_t               in_item,
  output logic                out_valid,
  output logic [OUT_BITS-1:0] out_value
);

  // stage 1
  logic  s1_valid;
  item_t s1_item;
  // stage 2
  logic                  s2_valid;
  logic                  s2_eval;
  idx_t                  s2_idx;
  logic [ENTRY_BITS-1:0] s2_val;
  idx_t                  s2_yi;
  idx_t                  s2_zi;
  frac_t                 s2_f  [3];
  frac_t                 s2_p2 [3];
  // stage 3
  logic                  s3_valid;
  logic                  s3_eval;
  idx_t                  s3_idx;
  logic [ENTRY_BITS-1:0] s3_val;
  idx_t                  s3_zi;
  frac_t                 s3_f  [3];
  frac_t                 s3_p3 [3];
  // stage 4
  logic  s4_valid;
  frac_t s4_f  [3];
  frac_t s4_p3 [3];
  frac_t s4_p4 [3];
  // stage 5
  logic  s5_valid;
  nval_t s5_g  [8];
  frac_t s5_p3 [3];
  frac_t s5_p4 [3];
  frac_t s5_p5 [3];
  // stage 6..9
  logic  s6_valid;
  nval_t s6_g  [8];
  fade_t s6_fd [3];
  logic  s7_valid;
  nval_t s7_l  [4];
  fade_t s7_fd [2];
  logic  s8_valid;
  nval_t s8_l  [2];
  fade_t s8_w;
  logic  s9_valid;
  nval_t s9_res;

  logic [ENTRY_BITS-1:0] p1 [2];
  logic [ENTRY_BITS-1:0] p2 [2][2];
  logic [ENTRY_BITS-1:0] h   [4][2];
  idx_t                  a2  [2];
  idx_t                  a3  [4];
  frac_t                 sq  [3];
  frac_t                 cu  [3];
  frac_t                 qu  [3];
  frac_t                 qi  [3];
  nval_t                 g   [8];
  pos_t                  c0  [3];
  pos_t                  c1  [3];

  // level 1 table, written as loads pass stage 1
  pn3_ram u_ram_l1 (
    .clk    (clk),
    .we     (s1_valid && !s1_item.is_eval),
    .waddr  (s1_item.idx),
    .wdata  (s1_item.value),
    .raddr0 (s1_item.xi),
    .raddr1 (s1_item.xi + idx_t'(1)),
    .rdata0 (p1[0]),
    .rdata1 (p1[1])
  );

  for (genvar j = 0; j < 2; j++) begin : g_l2
    assign a2[j] = idx_t'(p1[j]) + s2_yi;
    pn3_ram u_ram (
      .clk    (clk),
      .we     (s2_valid && !s2_eval),
      .waddr  (s2_idx),
      .wdata  (s2_val),
      .raddr0 (a2[j]),
      .raddr1 (a2[j] + idx_t'(1)),
      .rdata0 (p2[j][0]),
      .rdata1 (p2[j][1])
    );
  end

  // corner pair k: bit 0 picks the x side, bit 1 the y side
  for (genvar k = 0; k < 4; k++) begin : g_l3
    assign a3[k] = idx_t'(p2[k%2][k/2]) + s3_zi;
    pn3_ram u_ram (
      .clk    (clk),
      .we     (s3_valid && !s3_eval),
      .waddr  (s3_idx),
      .wdata  (s3_val),
      .raddr0 (a3[k]),
      .raddr1 (a3[k] + idx_t'(1)),
      .rdata0 (h[k][0]),
      .rdata1 (h[k][1])
    );
  end

  always_comb begin
    sq[0] = fx_mul(s1_item.fx, s1_item.fx);
    sq[1] = fx_mul(s1_item.fy, s1_item.fy);
    sq[2] = fx_mul(s1_item.fz, s1_item.fz);
    for (int d = 0; d < 3; d++) begin
      cu[d] = fx_mul(s2_p2[d], s2_f[d]);
      qu[d] = fx_mul(s3_p3[d], s3_f[d]);
      qi[d] = fx_mul(s4_p4[d], s4_f[d]);
      c0[d] = pos_t'({2'b00, s4_f[d]});
      c1[d] = pos_t'({2'b11, s4_f[d]});
    end
    for (int i = 0; i < 8; i++) begin
      g[i] = grad(h[i%4][i/4][3:0], i[0] ? c1[0] : c0[0], i[1] ? c1[1] : c0[1],
                  i[2] ? c1[2] : c0[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      s6_valid  <= 1'b0;
      s7_valid  <= 1'b0;
      s8_valid  <= 1'b0;
      s9_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid && s3_eval;
      s5_valid  <= s4_valid;
      s6_valid  <= s5_valid;
      s7_valid  <= s6_valid;
      s8_valid  <= s7_valid;
      s9_valid  <= s8_valid;
      out_valid <= s9_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [FRAC_BITS+3:0] v;
    logic [FRAC_BITS+OUT_BITS+3:0] q;
    s1_item <= in_item;

    s2_eval  <= s1_item.is_eval;
    s2_idx   <= s1_item.idx;
    s2_val   <= s1_item.value;
    s2_yi    <= s1_item.yi;
    s2_zi    <= s1_item.zi;
    s2_f[0]  <= s1_item.fx;
    s2_f[1]  <= s1_item.fy;
    s2_f[2]  <= s1_item.fz;
    s2_p2    <= sq;

    s3_eval <= s2_eval;
    s3_idx  <= s2_idx;
    s3_val  <= s2_val;
    s3_zi   <= s2_zi;
    s3_f    <= s2_f;
    s3_p3   <= cu;

    s4_f  <= s3_f;
    s4_p3 <= s3_p3;
    s4_p4 <= qu;

    s5_g  <= g;
    s5_p3 <= s4_p3;
    s5_p4 <= s4_p4;
    s5_p5 <= qi;

    s6_g <= s5_g;
    for (int d = 0; d < 3; d++) begin
      s6_fd[d] <= fade_mix(s5_p3[d], s5_p4[d], s5_p5[d]);
    end

    for (int i = 0; i < 4; i++) begin
      s7_l[i] <= lerp(s6_fd[0], s6_g[2*i], s6_g[2*i+1]);
    end
    s7_fd[0] <= s6_fd[1];
    s7_fd[1] <= s6_fd[2];

    s8_l[0] <= lerp(s7_fd[0], s7_l[0], s7_l[1]);
    s8_l[1] <= lerp(s7_fd[0], s7_l[2], s7_l[3]);
    s8_w    <= s7_fd[1];

    s9_res <= lerp(s8_w, s8_l[0], s8_l[1]);

    v = (FRAC_BITS+4)'(s9_res) + (FRAC_BITS+4)'(1 << FRAC_BITS);
    if (v < 0) begin
      v = '0;
    end
    q = {1'b0, v[FRAC_BITS+2:0], {OUT_BITS{1'b0}}} >> (FRAC_BITS + 1);
    if (q > (FRAC_BITS+OUT_BITS+4)'((1 << OUT_BITS) - 1)) begin
      out_value <= '1;
    end else begin
      out_value <= q[OUT_BITS-1:0];
    end
  end

endmodule

/* src/perlin_noise_3d_unit.sv */
// 3-d improved gradient noise unit, 8.16 fixed-point coordinates in, q0.16 noise out
// depends on pn3_pkg, pn3_front, pn3_queue, pn3_back
// path: an evaluate beat passes the queue, stages s1 to s9 and the output register before its noise beat
// throughput: one beat per cycle, set by the seven replicated two-port table copies
// reset: synchronous, clears queue and pipeline valids; table contents hold until loaded
// busy is high during reset; the receiver cannot stall results
module perlin_noise_3d_unit import pn3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  action,
  input  logic [IDX_BITS-1:0]   entry_index,
  input  logic [ENTRY_BITS-1:0] entry_value,
  input  logic [COORD_BITS-1:0] coord_x,
  input  logic [COORD_BITS-1:0] coord_y,
  input  logic [COORD_BITS-1:0] coord_z,
  output logic                  noise_valid,
  output logic [OUT_BITS-1:0]   noise_value
);

  queue_stat_t qstat;
  logic        push;
  item_t       item;
  item_t       head;

  pn3_front u_front (
    .rst         (rst),
    .start       (start),
    .action      (action),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .qstat       (qstat),
    .busy        (busy),
    .push        (push),
    .item        (item)
  );

  pn3_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (item),
    .pop       (!qstat.empty),
    .head      (head),
    .stat      (qstat)
  );

  pn3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!qstat.empty),
    .in_item   (head),
    .out_valid (noise_valid),
    .out_value (noise_value)
  );

  // the back end drains every cycle, so the queue never fills
  a_never_full : assert property (@(posedge clk) disable iff (rst) !qstat.full)
    else $error("queue filled");

  a_eval_gives_result : assert property (@(posedge clk) disable iff (rst)
    (push && action == ACT_EVAL) |-> ##11 noise_valid)
    else $error("evaluate beat lost");

  a_result_has_source : assert property (@(posedge clk) disable iff (rst)
    noise_valid |-> $past(push && action == ACT_EVAL, 11))
    else $error("result without evaluate beat");

endmodule

/* sim/perlin_noise_3d_unit_test.sv */
// testbench for perlin_noise_3d_unit: fills the permutation table, then streams
// directed and random noise lookups mixed with table loads; a scoreboard class predicts every noise beat
// depends on pn3_pkg and perlin_noise_3d_unit
`timescale 1ns / 1ps

module perlin_noise_3d_unit_test;
  import pn3_pkg::*;

  class noise_scoreboard;
    logic [ENTRY_BITS-1:0] perm [TABLE_SIZE];
    logic [OUT_BITS-1:0]   noise_fifo[$];
    int                    errors;
    int                    loads;
    int                    evals;
    int                    noise_seen;

    function int pending();
      return noise_fifo.size();
    endfunction

    function int lookup(int i);
      return perm[i % TABLE_SIZE];
    endfunction

    function longint fade(longint t);
      longint t2, t3, t4, t5, r;
      t2 = (t * t) >> FRAC_BITS;
      t3 = (t2 * t) >> FRAC_BITS;
      t4 = (t3 * t) >> FRAC_BITS;
      t5 = (t4 * t) >> FRAC_BITS;
      r = 6 * t5 - 15 * t4 + 10 * t3;
      if (r < 0) r = 0;
      if (r > (64'sd1 << FRAC_BITS)) r = 64'sd1 << FRAC_BITS;
      return r;
    endfunction

    function longint blend(longint t, longint a, longint b);
      return a + ((t * (b - a)) >>> FRAC_BITS);
    endfunction

    function longint corner(int hash, longint x, longint y, longint z);
      logic [3:0] h;
      longint u, v;
      h = hash[3:0];
      u = (h < 8) ? x : y;
      v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
      return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function void note(logic act, logic [IDX_BITS-1:0] idx, logic [ENTRY_BITS-1:0] val,
                       logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                       logic [COORD_BITS-1:0] cz);
      int xi, yi, zi, a, b, aa, ab, ba, bb;
      longint one, x, y, z, x1, y1, z1, u, v, w, res, val_n, q;
      if (act == ACT_LOAD) begin
        perm[idx] = val;
        loads++;
        return;
      end
      evals++;
      one = 64'sd1 << FRAC_BITS;
      xi = cx[COORD_BITS-1:FRAC_BITS];
      yi = cy[COORD_BITS-1:FRAC_BITS];
      zi = cz[COORD_BITS-1:FRAC_BITS];
      x = cx[FRAC_BITS-1:0];
      y = cy[FRAC_BITS-1:0];
      z = cz[FRAC_BITS-1:0];
      x1 = x - one;
      y1 = y - one;
      z1 = z - one;
      u = fade(x);
      v = fade(y);
      w = fade(z);
      a  = (lookup(xi) + yi) % TABLE_SIZE;
      aa = (lookup(a) + zi) % TABLE_SIZE;
      ab = (lookup(a + 1) + zi) % TABLE_SIZE;
      b  = (lookup(xi + 1) + yi) % TABLE_SIZE;
      ba = (lookup(b) + zi) % TABLE_SIZE;
      bb = (lookup(b + 1) + zi) % TABLE_SIZE;
      res = blend(w,
        blend(v,
          blend(u, corner(lookup(aa), x, y, z), corner(lookup(ba), x1, y, z)),
          blend(u, corner(lookup(ab), x, y1, z), corner(lookup(bb), x1, y1, z))),
        blend(v,
          blend(u, corner(lookup(aa + 1), x, y, z1), corner(lookup(ba + 1), x1, y, z1)),
          blend(u, corner(lookup(ab + 1), x, y1, z1),
                corner(lookup(bb + 1), x1, y1, z1))));
      val_n = res + one;
      if (val_n < 0) val_n = 0;
      q = (val_n << OUT_BITS) >> (FRAC_BITS + 1);
      if (q > (64'sd1 << OUT_BITS) - 1) q = (64'sd1 << OUT_BITS) - 1;
      noise_fifo.push_back(q[OUT_BITS-1:0]);
    endfunction

    function void check(logic [OUT_BITS-1:0] got);
      logic [OUT_BITS-1:0] want;
      noise_seen++;
      if (noise_fifo.size() == 0) begin
        $display("%0t: unexpected noise beat, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = noise_fifo.pop_front();
      if (got !== want) begin
        $display("%0t: noise_value mismatch, expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 2000;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  action;
  logic [IDX_BITS-1:0]   entry_index;
  logic [ENTRY_BITS-1:0] entry_value;
  logic [COORD_BITS-1:0] coord_x;
  logic [COORD_BITS-1:0] coord_y;
  logic [COORD_BITS-1:0] coord_z;
  logic                  noise_valid;
  logic [OUT_BITS-1:0]   noise_value;

  noise_scoreboard sb;
  int              idle_pct;
  int              quiet_cycles;

  perlin_noise_3d_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .entry_index(entry_index), .entry_value(entry_value),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .noise_valid(noise_valid), .noise_value(noise_value)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        sb.note(action, entry_index, entry_value, coord_x, coord_y, coord_z);
      end
      if (noise_valid) begin
        sb.check(noise_value);
      end
      if ((start && !busy) || noise_valid) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // one beat, with random idle cycles ahead of it
  task automatic send_beat(logic act, logic [IDX_BITS-1:0] idx,
                           logic [ENTRY_BITS-1:0] val, logic [COORD_BITS-1:0] cx,
                           logic [COORD_BITS-1:0] cy, logic [COORD_BITS-1:0] cz);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      action = 1'($urandom);
      @(negedge clk);
    end
    start = 1'b1;
    action = act;
    entry_index = idx;
    entry_value = val;
    coord_x = cx;
    coord_y = cy;
    coord_z = cz;
    // busy only moves at a rising edge, so its value here holds through the next one
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_load(int idx, int val);
    send_beat(ACT_LOAD, IDX_BITS'(idx), ENTRY_BITS'(val), COORD_BITS'($urandom),
              COORD_BITS'($urandom), COORD_BITS'($urandom));
  endtask

  task automatic send_eval(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                           logic [COORD_BITS-1:0] cz);
    send_beat(ACT_EVAL, IDX_BITS'($urandom), ENTRY_BITS'($urandom), cx, cy, cz);
  endtask

  function automatic logic [COORD_BITS-1:0] rand_coord();
    logic [COORD_BITS-1:0] c;
    c = COORD_BITS'($urandom);
    case ($urandom_range(7))
      0: c[FRAC_BITS-1:0] = '0;
      1: c[FRAC_BITS-1:0] = '1;
      2: c[COORD_BITS-1:FRAC_BITS] = '1;
      3: c = '0;
      default: ;
    endcase
    return c;
  endfunction

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    sb = new();
    idle_pct = 14;
    quiet_cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    action = ACT_LOAD;
    entry_index = '0;
    entry_value = '0;
    coord_x = '0;
    coord_y = '0;
    coord_z = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // whole table first, so no lookup reaches an unloaded slot
    for (int i = 0; i < TABLE_SIZE; i++) send_load(i, $urandom_range(255));
    send_load(0, 0);
    send_load(TABLE_SIZE - 1, 255);

    send_eval('0, '0, '0);
    send_eval('1, '1, '1);
    send_eval(24'h00_8000, 24'h00_8000, 24'h00_8000);
    send_eval(24'hFF_0000, 24'hFF_FFFF, 24'h00_0001);
    send_eval(24'hFF_FFFF, 24'h00_0000, 24'hFF_8000);
    send_eval(24'h01_4000, 24'h80_C000, 24'h7F_2000);
    send_eval(24'h00_0001, 24'h00_FFFF, 24'hFF_0001);
    send_load(1, 128);
    send_eval(24'h00_8000, 24'h01_8000, 24'h02_8000);
    drain();

    for (int i = 0; i < 1000; i++) begin
      if (i == 333) begin
        drain();
        idle_pct = 58;
      end else if (i == 666) begin
        drain();
        idle_pct = 0;
      end
      if ($urandom_range(9) == 0) send_load($urandom_range(255), $urandom_range(255));
      else send_eval(rand_coord(), rand_coord(), rand_coord());
    end
    drain();

    $display("covered %0d table loads and %0d noise lookups, %0d noise beats checked",
             sb.loads, sb.evals, sb.noise_seen);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
